/* rtl/gtq_pkg.sv */
// Shared types, constants and codes for the grouped team queue.
package gtq_pkg;

  localparam int ID_COUNT_DEF = 1024;
  localparam int TEAMS_DEF    = 16;
  localparam int CAPACITY_DEF = 256;

  localparam int OP_W     = 2;
  localparam int ELEM_W   = 10;
  localparam int TEAM_W   = 4;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_MAP   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_DEQ   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture the request
    logic look;      // first lookup step
    logic exec;      // second step: team list reads
    logic fetch;     // third step: served slot reads
    logic commit;    // update state and result
    logic sweep;     // clear pass step
    logic sweep_go;  // start clear pass
  } gtq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sweep_done;
    logic is_clear;
  } gtq_stat_t;

endpackage

/* rtl/gtq_ctrl.sv */
// Controller state machine of the grouped team queue.
module gtq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output gtq_pkg::gtq_cmd_t   cmd,
  input  gtq_pkg::gtq_stat_t  stat
);
  import gtq_pkg::*;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_FETCH = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SWEEP = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   hold, hold_next;

  // Accept only when no result is waiting.
  assign in_ready  = (state == S_IDLE) && !hold;
  assign out_valid = hold;

  always_comb begin
    state_next = state;
    hold_next  = hold;
    cmd        = '0;
    if (hold && out_ready) hold_next = 1'b0;
    case (state)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        hold_next  = 1'b1;
        if (stat.is_clear) begin
          cmd.sweep_go = 1'b1;
          state_next   = S_SWEEP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      hold  <= 1'b0;
    end else begin
      state <= state_next;
      hold  <= hold_next;
    end
  end

endmodule

/* rtl/gtq_dp.sv */
// Datapath of the grouped team queue: membership, slot pool and team order.
module gtq_dp #(
  parameter int ID_COUNT = gtq_pkg::ID_COUNT_DEF,
  parameter int TEAMS    = gtq_pkg::TEAMS_DEF,
  parameter int CAPACITY = gtq_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [gtq_pkg::OP_W-1:0]       op,
  input  logic [gtq_pkg::ELEM_W-1:0]     element,
  input  logic [gtq_pkg::TEAM_W-1:0]     team,
  input  gtq_pkg::gtq_cmd_t              cmd,
  output gtq_pkg::gtq_stat_t             stat,
  output logic [gtq_pkg::STATUS_W-1:0]   status,
  output logic [gtq_pkg::ELEM_W-1:0]     out_element,
  output logic [gtq_pkg::TEAM_W-1:0]     out_team
);
  import gtq_pkg::*;

  localparam int IW  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int TW  = (TEAMS > 1) ? $clog2(TEAMS) : 1;
  localparam int SW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int OCW = $clog2(TEAMS + 1);
  // Sweep covers the larger of the id table and the slot pool.
  localparam int SWN = (ID_COUNT > CAPACITY) ? ID_COUNT : CAPACITY;
  localparam int SWW = $clog2(SWN);

  // Memories.
  logic [TEAM_W-1:0] member_mem [ID_COUNT];
  logic [ELEM_W-1:0] value_mem  [CAPACITY];
  logic [SW-1:0]     next_mem   [CAPACITY];
  logic [SW-1:0]     head_mem   [TEAMS];
  logic [SW-1:0]     tail_mem   [TEAMS];
  logic [TW-1:0]     ring_mem   [TEAMS];
  logic [TEAMS-1:0]  busy;

  logic [SW-1:0]  free_head;
  logic [CW-1:0]  free_count;
  logic [TW-1:0]  order_read, order_write;
  logic [OCW-1:0] order_count;

  // Captured request and intermediate reads.
  logic [OP_W-1:0]   op_q;
  logic [ELEM_W-1:0] elem_q;
  logic [TEAM_W-1:0] team_q;
  logic [IW-1:0]     id_q;
  logic [TEAM_W-1:0] mem_rd;
  logic [TW-1:0]     ring_rd;
  logic [TW-1:0]     t_q;
  logic [SW-1:0]     head_rd, tail_rd, nfree_rd, nhead_rd;
  logic [ELEM_W-1:0] val_rd;

  logic [SWW:0] sweep_cnt;
  logic         sweep_last;

  assign sweep_last      = (sweep_cnt == (SWW+1)'(SWN - 1));
  assign stat.sweep_done = sweep_last && cmd.sweep;
  assign stat.is_clear   = (op_q == OP_CLEAR);

  // Team of enqueued element; stored memberships are always in range.
  logic [TW-1:0] enq_team;
  assign enq_team = TW'(mem_rd);

  // Capture request, step counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op;
      elem_q <= element;
      team_q <= team;
      id_q   <= IW'(32'(element) % ID_COUNT);
    end
    if (rst || cmd.sweep_go) sweep_cnt <= '0;
    else if (cmd.sweep && !sweep_last) sweep_cnt <= sweep_cnt + 1'b1;
  end

  // Step one: membership and order lookups.
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      mem_rd  <= member_mem[id_q];
      ring_rd <= ring_mem[order_read];
      nfree_rd <= next_mem[free_head];
    end
  end

  // Step two: team lists and served slot.
  logic [TW-1:0] t_sel;
  assign t_sel = (op_q == OP_ENQ) ? enq_team : ring_rd;
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      t_q     <= t_sel;
      head_rd <= head_mem[t_sel];
      tail_rd <= tail_mem[t_sel];
    end
  end

  // Step three: served slot value and its successor.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      val_rd   <= value_mem[head_rd];
      nhead_rd <= next_mem[head_rd];
    end
  end

  // Commit: state update and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= '0;
      free_head   <= '0;
      free_count  <= CW'(CAPACITY);
      order_read  <= '0;
      order_write <= '0;
      order_count <= '0;
    end else if (cmd.sweep_go) begin
      busy        <= '0;
      free_head   <= '0;
      free_count  <= CW'(CAPACITY);
      order_read  <= '0;
      order_write <= '0;
      order_count <= '0;
    end else if (cmd.commit) begin
      case (op_q)
        OP_ENQ: begin
          if (free_count != '0) begin
            free_head  <= nfree_rd;
            free_count <= free_count - 1'b1;
            if (!busy[t_q]) begin
              busy[t_q]   <= 1'b1;
              order_write <= (order_write == TW'(TEAMS - 1)) ? '0 : order_write + 1'b1;
              order_count <= order_count + 1'b1;
            end
          end
        end
        OP_DEQ: begin
          if (order_count != '0) begin
            if (head_rd == tail_rd) begin
              busy[t_q]   <= 1'b0;
              order_read  <= (order_read == TW'(TEAMS - 1)) ? '0 : order_read + 1'b1;
              order_count <= order_count - 1'b1;
            end
            free_head  <= head_rd;
            free_count <= free_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Memory writes: commit updates and the clearing pass.
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      if (sweep_cnt < (SWW+1)'(ID_COUNT)) member_mem[IW'(sweep_cnt)] <= '0;
      if (sweep_cnt < (SWW+1)'(CAPACITY))
        next_mem[SW'(sweep_cnt)] <= SW'(sweep_cnt + 1'b1);
    end else if (cmd.commit) begin
      case (op_q)
        OP_MAP: begin
          if (32'(team_q) < TEAMS) member_mem[id_q] <= team_q;
        end
        OP_ENQ: begin
          if (free_count != '0) begin
            value_mem[free_head] <= elem_q;
            tail_mem[t_q] <= free_head;
            if (!busy[t_q]) begin
              head_mem[t_q]         <= free_head;
              ring_mem[order_write] <= t_q;
            end else begin
              next_mem[tail_rd] <= free_head;
            end
          end
        end
        OP_DEQ: begin
          if (order_count != '0) begin
            if (head_rd != tail_rd) head_mem[t_q] <= nhead_rd;
            next_mem[head_rd] <= free_head;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status      <= ST_OK;
      out_element <= '0;
      out_team    <= '0;
      case (op_q)
        OP_ENQ: begin
          out_team <= TEAM_W'(t_q);
          if (free_count == '0) status <= ST_FULL;
        end
        OP_DEQ: begin
          if (order_count == '0) begin
            status <= ST_EMPTY;
          end else begin
            out_element <= val_rd;
            out_team    <= TEAM_W'(t_q);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/grouped_team_queue.sv */
// Top level of the grouped team queue.
//
// One request in, one result out, on valid/ready channels.
// Request: op (map, enqueue, dequeue, clear), element, team.
// Result: status, out_element, out_team for every request.
// After the request transfer, four steps lead to the result: a membership
// and order lookup, a team list read, a served slot read, and a commit that
// writes the linked lists and loads the result register. The chain of
// dependent reads through the slot pool memories sets these steps.
// The result stays in its register until the receiver takes it; a
// new request is taken in the cycle after that result has been transferred.
// Reset and a clear request run a clearing pass over the membership table
// and the free list, during which no request is taken. The clear result is
// offered at the start of the pass.
// After the pass all elements belong to team 0 and all queues are empty.
// Dequeue from an empty queue reports status 1; enqueue into a full pool
// reports status 2 and changes nothing.
module grouped_team_queue #(
  parameter int ID_COUNT = gtq_pkg::ID_COUNT_DEF,
  parameter int TEAMS    = gtq_pkg::TEAMS_DEF,
  parameter int CAPACITY = gtq_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gtq_pkg::OP_W-1:0]      op,
  input  logic [gtq_pkg::ELEM_W-1:0]    element,
  input  logic [gtq_pkg::TEAM_W-1:0]    team,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gtq_pkg::STATUS_W-1:0]  status,
  output logic [gtq_pkg::ELEM_W-1:0]    out_element,
  output logic [gtq_pkg::TEAM_W-1:0]    out_team
);
  import gtq_pkg::*;

  gtq_cmd_t  cmd;
  gtq_stat_t stat;

  gtq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  gtq_dp #(.ID_COUNT(ID_COUNT), .TEAMS(TEAMS), .CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .op, .element, .team, .cmd, .stat,
    .status, .out_element, .out_team
  );

endmodule

/* rtl/gtq_check.sv */
// Port checker for the grouped team queue, bound to the top level.
module gtq_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gtq_pkg::STATUS_W-1:0]  status,
  input logic [gtq_pkg::ELEM_W-1:0]    out_element,
  input logic [gtq_pkg::TEAM_W-1:0]    out_team
);
  import gtq_pkg::*;

  // No new request while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");

  // A transfer in leads to a valid result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##5 out_valid) else $error("result late");

  // Status never holds an unused code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("bad status");

  // Errors carry no element.
  a_err_elem: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (out_element == '0))
    else $error("element on error");

  // Held result stays valid and its team stable while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_team)))
    else $error("result changed under stall");

endmodule

bind grouped_team_queue gtq_check u_gtq_check (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
  .status, .out_element, .out_team
);

/* sim/testbench.sv */
// Self-checking testbench for the grouped team queue: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;
  import gtq_pkg::*;

  localparam int N_IDS   = 1024;
  localparam int N_TEAMS = 16;
  localparam int N_SLOTS = 256;
  localparam int N_RAND  = 435;
  localparam int N_EXP   = 64;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [ELEM_W-1:0]   el;
    logic [TEAM_W-1:0]   tm;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ELEM_W-1:0]   el;
    logic [TEAM_W-1:0]   tm;
    logic                typed;
    result_t             res;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [OP_W-1:0]     op;
  logic [ELEM_W-1:0]   element;
  logic [TEAM_W-1:0]   team;
  logic [STATUS_W-1:0] status;
  logic [ELEM_W-1:0]   out_element;
  logic [TEAM_W-1:0]   out_team;

  // Queue model state
  logic [TEAM_W-1:0] q_member [N_IDS];
  logic [ELEM_W-1:0] q_value  [N_SLOTS];
  logic [7:0]        q_next   [N_SLOTS];
  logic [7:0]        q_free_head;
  int                q_free_cnt;
  logic [7:0]        q_head   [N_TEAMS];
  logic [7:0]        q_tail   [N_TEAMS];
  logic              q_busy   [N_TEAMS];
  logic [TEAM_W-1:0] q_order  [N_TEAMS];
  logic [3:0]        q_rd, q_wr;
  int                q_order_cnt;

  // Expected results in transfer order
  result_t exp_fifo [N_EXP];
  int      exp_wr = 0, exp_rd = 0;
  int      errors = 0;
  int      n_results = 0, n_empty = 0, n_full = 0, n_served = 0;
  int      send_idle = 0, recv_stall = 0;

  grouped_team_queue uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .element(element), .team(team),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_element(out_element), .out_team(out_team)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Empty all queues and return every id to team 0
  function automatic void queue_clear();
    for (int i = 0; i < N_IDS; i++) q_member[i] = '0;
    for (int i = 0; i < N_SLOTS; i++) begin
      q_value[i] = '0;
      q_next[i]  = 8'((i + 1) % N_SLOTS);
    end
    for (int i = 0; i < N_TEAMS; i++) begin
      q_head[i] = '0; q_tail[i] = '0; q_busy[i] = 1'b0; q_order[i] = '0;
    end
    q_free_head = '0;
    q_free_cnt  = N_SLOTS;
    q_rd = '0; q_wr = '0; q_order_cnt = 0;
  endfunction

  // Apply one request and return the result it produces
  function automatic result_t queue_apply(logic [OP_W-1:0] o, logic [ELEM_W-1:0] e,
                                          logic [TEAM_W-1:0] t);
    result_t r;
    logic [TEAM_W-1:0] tt;
    logic [7:0] s;
    r = '0;
    case (o)
      OP_MAP: begin
        q_member[e] = t;
      end
      OP_ENQ: begin
        tt = q_member[e];
        r.tm = tt;
        if (q_free_cnt == 0) begin
          r.st = ST_FULL;
        end else begin
          s = q_free_head;
          q_free_head = q_next[s];
          q_free_cnt--;
          q_value[s] = e;
          if (!q_busy[tt]) begin
            q_busy[tt] = 1'b1;
            q_head[tt] = s;
            q_tail[tt] = s;
            q_order[q_wr] = tt;
            q_wr++;
            q_order_cnt++;
          end else begin
            q_next[q_tail[tt]] = s;
            q_tail[tt] = s;
          end
        end
      end
      OP_DEQ: begin
        if (q_order_cnt == 0) begin
          r.st = ST_EMPTY;
        end else begin
          tt = q_order[q_rd];
          s = q_head[tt];
          r.el = q_value[s];
          r.tm = tt;
          if (s == q_tail[tt]) begin
            q_busy[tt] = 1'b0;
            q_rd++;
            q_order_cnt--;
          end else begin
            q_head[tt] = q_next[s];
          end
          q_next[s] = q_free_head;
          q_free_head = s;
          q_free_cnt++;
        end
      end
      default: queue_clear();
    endcase
    return r;
  endfunction

  // Offer one request, hold it until transfer, then record its expected result
  task automatic send_request(logic [OP_W-1:0] o, logic [ELEM_W-1:0] e,
                              logic [TEAM_W-1:0] t, logic typed, result_t typed_res);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    element  <= e;
    team     <= t;
    do @(posedge clk); while (!in_ready);
    r = queue_apply(o, e, t);
    exp_fifo[exp_wr % N_EXP] = typed ? typed_res : r;
    exp_wr++;
  endtask

  // Drive receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (exp_wr == exp_rd) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d element %0d team %0d",
                   status, out_element, out_team);
      end else begin
        want = exp_fifo[exp_rd % N_EXP];
        exp_rd++;
        if (want.st == ST_EMPTY) n_empty++;
        if (want.st == ST_FULL) n_full++;
        if (want.st == ST_OK && want.el != '0) n_served++;
        if (status != want.st || out_element != want.el || out_team != want.tm) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected st %0d el %0d tm %0d, got st %0d el %0d tm %0d",
                     want.st, want.el, want.tm, status, out_element, out_team);
        end
      end
    end
  end

  // Hard stop
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", exp_wr - exp_rd);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    logic [OP_W-1:0] o;
    logic [ELEM_W-1:0] e;
    int pick, waited;

    rst <= 1'b1; in_valid <= 1'b0; op <= OP_MAP; element <= '0; team <= '0;
    queue_clear();

    // op, element, team, typed, {status, out_element, out_team}
    rows = '{
      '{OP_DEQ,   10'd0,    4'd0,  1'b1, '{ST_EMPTY, 10'd0, 4'd0}},
      '{OP_MAP,   10'd1023, 4'd15, 1'b1, '{ST_OK, 10'd0, 4'd0}},
      '{OP_ENQ,   10'd1023, 4'd0,  1'b1, '{ST_OK, 10'd0, 4'd15}},
      '{OP_ENQ,   10'd0,    4'd15, 1'b1, '{ST_OK, 10'd0, 4'd0}},
      '{OP_MAP,   10'd682,  4'd10, 1'b1, '{ST_OK, 10'd0, 4'd0}},
      '{OP_MAP,   10'd341,  4'd5,  1'b1, '{ST_OK, 10'd0, 4'd0}},
      '{OP_ENQ,   10'd341,  4'd0,  1'b0, '0},
      '{OP_ENQ,   10'd682,  4'd0,  1'b0, '0},
      '{OP_ENQ,   10'd1023, 4'd0,  1'b0, '0},
      '{OP_ENQ,   10'd1,    4'd0,  1'b0, '0},
      '{OP_DEQ,   10'd0,    4'd0,  1'b1, '{ST_OK, 10'd1023, 4'd15}},
      '{OP_DEQ,   10'd0,    4'd0,  1'b0, '0},
      '{OP_DEQ,   10'd0,    4'd0,  1'b0, '0},
      '{OP_DEQ,   10'd0,    4'd0,  1'b0, '0},
      '{OP_DEQ,   10'd0,    4'd0,  1'b0, '0},
      '{OP_DEQ,   10'd0,    4'd0,  1'b0, '0},
      '{OP_DEQ,   10'd0,    4'd0,  1'b1, '{ST_EMPTY, 10'd0, 4'd0}},
      '{OP_ENQ,   10'd341,  4'd0,  1'b0, '0},
      '{OP_CLEAR, 10'd1023, 4'd15, 1'b1, '{ST_OK, 10'd0, 4'd0}},
      '{OP_DEQ,   10'd0,    4'd0,  1'b1, '{ST_EMPTY, 10'd0, 4'd0}},
      '{OP_ENQ,   10'd1023, 4'd0,  1'b1, '{ST_OK, 10'd0, 4'd0}},
      '{OP_DEQ,   10'd0,    4'd0,  1'b1, '{ST_OK, 10'd1023, 4'd0}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      rw = rows[i];
      send_request(rw.op, rw.el, rw.tm, rw.typed, rw.res);
    end

    // Random traffic; a long enqueue run in the middle fills the pool
    for (int i = 0; i < N_RAND; i++) begin
      if (i < 110) begin
        send_idle = 0; recv_stall = 0;
      end else if (i < 220) begin
        send_idle = 45; recv_stall = 0;
      end else if (i < 330) begin
        send_idle = 0; recv_stall = 45;
      end else begin
        send_idle = 11; recv_stall = 11;
      end
      pick = $urandom_range(99);
      if (i >= 100 && i < 370) o = OP_ENQ;
      else if (pick < 20) o = OP_MAP;
      else if (pick < 58) o = OP_ENQ;
      else if (pick < 97) o = OP_DEQ;
      else o = OP_CLEAR;
      e = ($urandom_range(1) == 0) ? ELEM_W'($urandom_range(31)) : ELEM_W'($urandom);
      send_request(o, e, TEAM_W'($urandom), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain
    waited = 0;
    while (exp_wr != exp_rd && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    $display("covered %0d results: %0d served, %0d empty dequeues, %0d full-pool enqueues",
             n_results, n_served, n_empty, n_full);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, exp_wr - exp_rd);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
